### hw/rtl/rkeq_pkg.sv
`default_nettype none

package rkeq_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_ROTATE_LOCKOUT = 2'd0;
    localparam cfg_idx_t REG_LONG_PRESS     = 2'd1;
    localparam cfg_idx_t REG_SHORT_PRESS    = 2'd2;
    localparam cfg_idx_t REG_RELEASE_STABLE = 2'd3;
    localparam int CFG_DATA_W = 16;

    // register widths and reset values
    localparam int LOCKOUT_W  = 8;
    localparam int THRESH_W   = 16;
    localparam int RELEASE_W  = 8;
    localparam logic [LOCKOUT_W-1:0] ROTATE_LOCKOUT_RST = 8'd15;
    localparam logic [THRESH_W-1:0]  LONG_PRESS_RST     = 16'd400;
    localparam logic [THRESH_W-1:0]  SHORT_PRESS_RST    = 16'd60;
    localparam logic [RELEASE_W-1:0] RELEASE_STABLE_RST = 8'd10;

    // event codes
    localparam int EVENT_W = 3;
    typedef logic [EVENT_W-1:0] event_t;
    localparam event_t EV_NONE  = 3'd0;
    localparam event_t EV_CW    = 3'd1;
    localparam event_t EV_CCW   = 3'd2;
    localparam event_t EV_SHORT = 3'd3;
    localparam event_t EV_LONG  = 3'd4;

    // input action codes
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_EDGE = 1'b1;

endpackage

`default_nettype wire

### hw/rtl/rkeq_in_if.sv
`default_nettype none

interface rkeq_in_if;
    logic valid;
    logic ready;
    logic action;
    logic phase_b_level;
    logic switch_level;

    modport source (output valid, output action, output phase_b_level,
                    output switch_level, input ready);
    modport sink   (input valid, input action, input phase_b_level,
                    input switch_level, output ready);
endinterface

`default_nettype wire

### hw/rtl/rkeq_out_if.sv
`default_nettype none

interface rkeq_out_if;
    import rkeq_pkg::*;
    logic   valid;
    logic   ready;
    event_t event_res;

    modport source (output valid, output event_res, input ready);
    modport sink   (input valid, input event_res, output ready);
endinterface

`default_nettype wire

### hw/rtl/rkeq_cfg_if.sv
`default_nettype none

interface rkeq_cfg_if;
    import rkeq_pkg::*;
    logic                  valid;
    logic                  ready;
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/rotary_knob_event_qualifier.sv
`default_nettype none

// channel   dir  payload                                   transfer when
// in_ch     in   action, phase_b_level, switch_level       valid && ready
// out_ch    out  event_res (0 none .. 4 long press)        valid && ready
// cfg_ch    in   index (2 bit), data (16 bit)              valid && ready
//
// one result per input item, written to the result register, or to the skid entry while that is held
// one item per cycle while the skid entry is empty: counters update in the accept cycle
// a result register plus one skid entry hold results while out_ch stalls;
// in_ch.ready drops only while the skid entry is occupied
// cfg_ch is always ready; rst_n clears counters and loads register defaults

module rotary_knob_event_qualifier #(
    parameter int PRESS_COUNT_WIDTH = 16
) (
    input  wire           clk,
    input  wire           rst_n,
    rkeq_in_if.sink       in_ch,
    rkeq_out_if.source    out_ch,
    rkeq_cfg_if.sink      cfg_ch
);
    import rkeq_pkg::*;

    localparam int PW    = PRESS_COUNT_WIDTH;
    localparam int CMP_W = (PW > THRESH_W) ? PW : THRESH_W;

    // configuration registers
    logic [LOCKOUT_W-1:0] rotate_lockout_reg;
    logic [THRESH_W-1:0]  long_press_reg;
    logic [THRESH_W-1:0]  short_press_reg;
    logic [RELEASE_W-1:0] release_stable_reg;

    // knob state
    logic [LOCKOUT_W-1:0] lockout_reg, lockout_next;
    logic [PW-1:0]        press_reg, press_next;
    logic [RELEASE_W-1:0] release_reg, release_next;
    logic                 long_rep_reg, long_rep_next;
    event_t               event_next;

    // result register and skid entry
    logic   out_valid_reg, skid_valid_reg;
    event_t out_event_reg, skid_event_reg;

    logic in_fire, out_fire, cfg_fire;
    logic pressed;
    logic [PW-1:0]        press_inc;
    logic [RELEASE_W-1:0] release_inc;
    logic [CMP_W-1:0]     press_cmp, long_cmp, short_cmp;

    assign in_ch.ready   = !skid_valid_reg;
    assign cfg_ch.ready  = 1'b1;
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.event_res = out_event_reg;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_valid_reg && out_ch.ready;
    assign cfg_fire = cfg_ch.valid && cfg_ch.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotate_lockout_reg <= ROTATE_LOCKOUT_RST;
            long_press_reg     <= LONG_PRESS_RST;
            short_press_reg    <= SHORT_PRESS_RST;
            release_stable_reg <= RELEASE_STABLE_RST;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_ch.index)
                REG_ROTATE_LOCKOUT: rotate_lockout_reg <= cfg_ch.data[LOCKOUT_W-1:0];
                REG_LONG_PRESS:     long_press_reg     <= cfg_ch.data[THRESH_W-1:0];
                REG_SHORT_PRESS:    short_press_reg    <= cfg_ch.data[THRESH_W-1:0];
                REG_RELEASE_STABLE: release_stable_reg <= cfg_ch.data[RELEASE_W-1:0];
                default: ;
            endcase
        end
    end

    // saturating increments and widened compare operands
    assign pressed     = (in_ch.switch_level == 1'b0);
    assign press_inc   = (press_reg != {PW{1'b1}}) ? press_reg + 1'b1 : press_reg;
    assign release_inc = (release_reg != {RELEASE_W{1'b1}}) ? release_reg + 1'b1
                                                            : release_reg;
    assign long_cmp    = CMP_W'(long_press_reg);
    assign short_cmp   = CMP_W'(short_press_reg);

    // next state and event for one item
    always_comb
    begin
        lockout_next  = lockout_reg;
        press_next    = press_reg;
        release_next  = release_reg;
        long_rep_next = long_rep_reg;
        event_next    = EV_NONE;
        press_cmp     = CMP_W'(press_reg);
        if (in_ch.action == ACT_EDGE)
        begin
            if (lockout_reg == '0)
            begin
                event_next   = in_ch.phase_b_level ? EV_CCW : EV_CW;
                lockout_next = rotate_lockout_reg;
            end
        end
        else
        begin
            if (lockout_reg != '0)
            begin
                lockout_next = lockout_reg - 1'b1;
            end
            if (pressed)
            begin
                press_next   = press_inc;
                release_next = '0;
                press_cmp    = CMP_W'(press_inc);
                if (press_cmp >= long_cmp && !long_rep_reg)
                begin
                    event_next    = EV_LONG;
                    long_rep_next = 1'b1;
                end
            end
            else if (press_reg != '0)
            begin
                release_next = release_inc;
                if (release_inc >= release_stable_reg)
                begin
                    if (!long_rep_reg && press_cmp >= short_cmp)
                    begin
                        event_next = EV_SHORT;
                    end
                    press_next    = '0;
                    long_rep_next = 1'b0;
                    release_next  = '0;
                end
            end
        end
    end

    // state update on input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg  <= '0;
            press_reg    <= '0;
            release_reg  <= '0;
            long_rep_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            lockout_reg  <= lockout_next;
            press_reg    <= press_next;
            release_reg  <= release_next;
            long_rep_reg <= long_rep_next;
        end
    end

    // result register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg && out_fire)
            begin
                out_event_reg  <= skid_event_reg;
                skid_valid_reg <= 1'b0;
            end
            else if (in_fire)
            begin
                if (!out_valid_reg || out_fire)
                begin
                    out_event_reg <= event_next;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_event_reg <= event_next;
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            else
            begin
                // nothing moves, hold both entries
            end
        end
    end

    // checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while result register is empty");

    a_long_has_press: assert property (@(posedge clk) disable iff (!rst_n)
        long_rep_reg |-> (press_reg != '0))
        else $error("long press flagged with no press count");

    a_release_has_press: assert property (@(posedge clk) disable iff (!rst_n)
        (release_reg != '0) |-> (press_reg != '0))
        else $error("release count running with no press count");

    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_event_reg <= EV_LONG))
        else $error("result carries an undefined event code");

    a_edge_no_press_change: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_ch.action == ACT_EDGE) |=> $stable(press_reg))
        else $error("knob edge changed the press count");

endmodule

`default_nettype wire

### bench/rotary_knob_event_qualifier_test.sv
`default_nettype none

module rotary_knob_event_qualifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rkeq_pkg::*;

    localparam int PRESS_W = 16;

    // knob event predictor with its queue of pending events
    class knob_event_book;
        logic [LOCKOUT_W-1:0] lockout_len;
        logic [THRESH_W-1:0]  long_thr;
        logic [THRESH_W-1:0]  short_thr;
        logic [RELEASE_W-1:0] release_len;

        logic [LOCKOUT_W-1:0] lockout_cnt;
        logic [PRESS_W-1:0]   press_cnt;
        logic [7:0]           release_cnt;
        logic                 long_seen;

        event_t pending[$];
        int     errors;

        function new();
            lockout_len = ROTATE_LOCKOUT_RST;
            long_thr    = LONG_PRESS_RST;
            short_thr   = SHORT_PRESS_RST;
            release_len = RELEASE_STABLE_RST;
            lockout_cnt = '0;
            press_cnt   = '0;
            release_cnt = '0;
            long_seen   = 1'b0;
            errors      = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ROTATE_LOCKOUT: lockout_len = data[LOCKOUT_W-1:0];
                REG_LONG_PRESS:     long_thr    = data[THRESH_W-1:0];
                REG_SHORT_PRESS:    short_thr   = data[THRESH_W-1:0];
                REG_RELEASE_STABLE: release_len = data[RELEASE_W-1:0];
                default: ;
            endcase
        endfunction

        // work out the event of one accepted item and update the counters
        function void note_input(logic act, logic b_lvl, logic sw_lvl);
            event_t ev;
            ev = EV_NONE;
            if (act == ACT_EDGE)
            begin
                if (lockout_cnt == 0)
                begin
                    ev = b_lvl ? EV_CCW : EV_CW;
                    lockout_cnt = lockout_len;
                end
            end
            else
            begin
                if (lockout_cnt != 0)
                    lockout_cnt--;
                if (sw_lvl == 1'b0)
                begin
                    // pressed: count up with saturation
                    if (press_cnt != '1)
                        press_cnt++;
                    release_cnt = '0;
                    if (press_cnt >= long_thr && !long_seen)
                    begin
                        ev = EV_LONG;
                        long_seen = 1'b1;
                    end
                end
                else if (press_cnt != 0)
                begin
                    // released after a press: debounce the release
                    if (release_cnt != 8'hFF)
                        release_cnt++;
                    if (release_cnt >= release_len)
                    begin
                        if (!long_seen && press_cnt >= short_thr)
                            ev = EV_SHORT;
                        press_cnt   = '0;
                        long_seen   = 1'b0;
                        release_cnt = '0;
                    end
                end
            end
            pending.push_back(ev);
        endfunction

        function void check_result(event_t got);
            event_t want;
            if (pending.size() == 0)
            begin
                $error("event_res: no event pending, got %0d", got);
                errors++;
            end
            else
            begin
                want = pending.pop_front();
                if (got !== want)
                begin
                    $error("event_res: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction

        function void check_drained();
            if (pending.size() != 0)
            begin
                $error("event_res: %0d events never arrived, oldest expected %0d",
                       pending.size(), pending[0]);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rkeq_in_if  in_ch ();
    rkeq_out_if out_ch ();
    rkeq_cfg_if cfg_ch ();

    rotary_knob_event_qualifier #(
        .PRESS_COUNT_WIDTH (PRESS_W)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    knob_event_book book;
    int send_idle;
    int recv_idle;
    int hold_left;
    int sent;

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // transfer monitor on the rising edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (out_ch.valid && out_ch.ready)
                book.check_result(out_ch.event_res);
            if (in_ch.valid && in_ch.ready)
                book.note_input(in_ch.action, in_ch.phase_b_level, in_ch.switch_level);
            if (cfg_ch.valid && cfg_ch.ready)
                book.write_reg(cfg_ch.index, cfg_ch.data);
        end
    end

    // result receiver with random stalls and an occasional long hold-off
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ch.ready = 1'b0;
                hold_left--;
            end
            else
                out_ch.ready = ($urandom_range(99) >= recv_idle);
        end
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // one input transfer, with a random gap before it
    task automatic send(logic act, logic b_lvl, logic sw_lvl);
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid         = 1'b1;
        in_ch.action        = act;
        in_ch.phase_b_level = b_lvl;
        in_ch.switch_level  = sw_lvl;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic tick(logic sw_lvl);
        send(ACT_TICK, 1'($urandom_range(1)), sw_lvl);
    endtask

    task automatic turn();
        send(ACT_EDGE, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // wait until every pending event has come back
    task automatic settle();
        in_ch.valid = 1'b0;
        while (book.pending.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // write all four registers while idle; narrow registers get junk upper bits
    task automatic configure(int unsigned lock_v, int unsigned long_v,
                             int unsigned short_v, int unsigned rel_v);
        settle();
        write_reg(REG_ROTATE_LOCKOUT, {8'($urandom_range(255)), 8'(lock_v)});
        write_reg(REG_LONG_PRESS, 16'(long_v));
        write_reg(REG_SHORT_PRESS, 16'(short_v));
        write_reg(REG_RELEASE_STABLE, {8'($urandom_range(255)), 8'(rel_v)});
        cfg_ch.valid = 1'b0;
    endtask

    task automatic random_config();
        int unsigned long_v;
        long_v = $urandom_range(0, 40);
        configure($urandom_range(0, 12), long_v, $urandom_range(0, long_v + 3),
                  $urandom_range(0, 6));
    endtask

    // knob gestures: rotation bursts, presses with bounce, and noise
    task automatic run_gestures(int n);
        int first;
        int kind;
        int len;
        int i;
        first = sent;
        while (sent - first < n)
        begin
            kind = $urandom_range(9);
            if (kind < 4)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    turn();
                    repeat ($urandom_range(0, book.lockout_len + 2))
                        tick(1'($urandom_range(15) != 0));
                end
            end
            else if (kind < 8)
            begin
                case ($urandom_range(2))
                    0: len = $urandom_range(1, book.short_thr);
                    1: len = $urandom_range(book.short_thr, book.long_thr);
                    default: len = $urandom_range(book.long_thr, book.long_thr + 4);
                endcase
                for (i = 0; i < len; i++)
                begin
                    if ($urandom_range(19) == 0)
                        turn();
                    if ($urandom_range(29) == 0)
                        tick(1'b1);
                    tick(1'b0);
                end
                repeat (book.release_len + $urandom_range(0, 2))
                    tick(1'($urandom_range(24) != 0));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send(1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
            end
        end
    endtask

    // main sequence
    initial
    begin
        int p;
        int i;
        book      = new();
        send_idle = 30;
        recv_idle = 30;
        hold_left = 0;
        sent      = 0;
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.action        = ACT_TICK;
        in_ch.phase_b_level = 1'b0;
        in_ch.switch_level  = 1'b1;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_ROTATE_LOCKOUT;
        cfg_ch.data         = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset values: lockout boundary, then a short press at its threshold
        turn();
        repeat (15) tick(1'b1);
        turn();
        repeat (60) tick(1'b0);
        repeat (10) tick(1'b1);

        // directed: lockout, both directions, short and long press
        configure(2, 6, 3, 2);
        send(ACT_EDGE, 1'b0, 1'b1);
        send(ACT_EDGE, 1'b1, 1'b0);
        send(ACT_TICK, 1'b1, 1'b1);
        send(ACT_EDGE, 1'b1, 1'b1);
        send(ACT_TICK, 1'b0, 1'b1);
        send(ACT_EDGE, 1'b1, 1'b0);
        send(ACT_TICK, 1'b1, 1'b0);
        send(ACT_TICK, 1'b0, 1'b0);
        send(ACT_TICK, 1'b1, 1'b0);
        send(ACT_TICK, 1'b0, 1'b1);
        send(ACT_TICK, 1'b1, 1'b1);
        send(ACT_TICK, 1'b0, 1'b1);
        for (i = 0; i < 7; i++)
            tick(1'b0);
        tick(1'b1);
        tick(1'b1);

        // zero registers: no lockout, thresholds always met, instant release
        configure(0, 0, 0, 0);
        send(ACT_EDGE, 1'b1, 1'b0);
        send(ACT_EDGE, 1'b0, 1'b1);
        tick(1'b0);
        tick(1'b1);
        tick(1'b1);
        configure(0, 16'hFFFF, 0, 0);
        tick(1'b0);
        tick(1'b1);

        // top extremes: full lockout, unreachable thresholds, full release debounce
        send_idle = 0;
        recv_idle = 0;
        configure(8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        turn();
        turn();
        for (i = 0; i < 20; i++)
            tick(1'b0);
        turn();
        for (i = 0; i < 256; i++)
            tick(1'b1);
        send_idle = 30;
        recv_idle = 30;

        // random phases
        for (p = 0; p < 6; p++)
        begin
            random_config();
            if (p == 2)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            else
            begin
                send_idle = 30;
                recv_idle = 30;
            end
            if (p == 4)
            begin
                // receiver holds off while items keep coming
                send_idle = 0;
                hold_left = 80;
                run_gestures(30);
                send_idle = 30;
            end
            run_gestures(25);
        end

        // drain
        in_ch.valid = 1'b0;
        for (i = 0; i < 5000 && book.pending.size() != 0; i++)
            @(negedge clk);
        repeat (10) @(negedge clk);
        book.check_drained();
        if (book.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
